// ----- sv/dntp_pkg.sv -----
// Shared types and constants of the decimal number text parser.
package dntp_pkg;

    // One input transfer: a raw byte of the text field and its last-byte mark.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       field_end;
    } dntp_in_t;

    // One result transfer: the parsed number of a whole field.
    typedef struct packed {
        logic               ok;
        logic               negative;
        logic [63:0]        significand;
        logic signed [15:0] decimal_scale;
    } dntp_out_t;

    // Configuration seen by the front and back parts.
    typedef struct packed {
        logic [7:0] decimal_mark;
        logic [7:0] grouping_mark;
        logic       strict_mode;
    } dntp_cfg_t;

    // Classified byte passed from the front part to the back part.
    typedef struct packed {
        logic       field_end;
        logic       is_minus;
        logic       is_plus;
        logic       is_dec;
        logic       is_grp;
        logic       is_e;
        logic       is_digit;
        logic [3:0] digit;
    } dntp_cls_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SKIP = 3'd0,
        PH_LHS  = 3'd1,
        PH_RHS  = 3'd2,
        PH_EXP  = 3'd3,
        PH_STOP = 3'd4
    } dntp_phase_t;

    // Register file layout.
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_DECIMAL_MARK  = 2'd0;
    localparam logic [1:0] REG_GROUPING_MARK = 2'd1;
    localparam logic [1:0] REG_STRICT_MODE   = 2'd2;

    // Register reset values.
    localparam logic [7:0] DECIMAL_MARK_RST  = 8'd46;
    localparam logic [7:0] GROUPING_MARK_RST = 8'd44;
    localparam logic       STRICT_MODE_RST   = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_LOWER_E = 8'h65;
    localparam logic [7:0] CHAR_UPPER_E = 8'h45;

    // Saturation limit of the 16-bit counters.
    localparam logic [15:0] SAT16 = 16'hFFFF;

endpackage

// ----- sv/dntp_fifo.sv -----
// Two-entry queue that decouples a producer from a consumer.
module dntp_fifo
#(
    parameter int unsigned WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never exceeds the two entries.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue occupancy out of range");

    // A transfer in with none out on a non-full queue raises the occupancy by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue occupancy did not follow a write");

    // A transfer out with none in lowers the occupancy by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue occupancy did not follow a read");
`endif

endmodule

// ----- sv/dntp_front.sv -----
// Front part: classifies each incoming byte against the marks and characters.
module dntp_front
    import dntp_pkg::*;
(
    input  dntp_cfg_t cfg,
    input  dntp_in_t  item,
    output dntp_cls_t cls
);

    logic [7:0] digit_wide;

    assign digit_wide = item.text_byte - CHAR_ZERO;

    // Every test is done in parallel; the back part applies the priorities.
    always_comb
    begin
        cls.field_end = item.field_end;
        cls.is_minus  = (item.text_byte == CHAR_MINUS);
        cls.is_plus   = (item.text_byte == CHAR_PLUS);
        cls.is_dec    = (item.text_byte == cfg.decimal_mark);
        cls.is_grp    = (item.text_byte == cfg.grouping_mark);
        cls.is_e      = (item.text_byte == CHAR_LOWER_E) ||
                        (item.text_byte == CHAR_UPPER_E);
        cls.is_digit  = (item.text_byte >= CHAR_ZERO) && (item.text_byte <= CHAR_NINE);
        cls.digit     = digit_wide[3:0];
    end

endmodule

// ----- sv/dntp_back.sv -----
// Back part: runs the parse state machine and builds one result per field.
module dntp_back
    import dntp_pkg::*;
#(
    parameter int unsigned MAX_SIG_DIGITS = 19
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  dntp_cfg_t cfg,
    input  dntp_cls_t cls,
    input  logic      cls_empty,
    output logic      cls_pop,
    input  logic      res_full,
    output logic      res_push,
    output dntp_out_t res
);

    localparam logic [4:0] MaxKept = 5'(MAX_SIG_DIGITS);

    dntp_phase_t phase_reg,     phase_upd,     phase_next;
    logic [63:0] sum_reg,       sum_upd,       sum_next;
    logic [4:0]  kept_reg,      kept_upd,      kept_next;
    logic [15:0] dropped_reg,   dropped_upd,   dropped_next;
    logic [15:0] frac_reg,      frac_upd,      frac_next;
    logic [15:0] exp_reg,       exp_upd,       exp_next;
    logic        exp_neg_reg,   exp_neg_upd,   exp_neg_next;
    logic        sign_ok_reg,   sign_ok_upd,   sign_ok_next;
    logic        seen_reg,      seen_upd,      seen_next;
    logic        minus_reg,     minus_upd,     minus_next;
    logic        skipped_reg,   skipped_upd,   skipped_next;
    logic        stopped_reg,   stopped_upd,   stopped_next;

    logic               take;
    logic               take_int;
    logic               take_frac;
    logic               can_keep;
    logic [63:0]        sum_x10;
    logic [19:0]        exp_x10;
    logic               ok;
    logic signed [18:0] exp_signed;
    logic signed [18:0] scale_wide;
    logic signed [15:0] scale_sat;

    // A byte is taken when there is one and room for a result it may cause.
    assign cls_pop  = !cls_empty && (!cls.field_end || !res_full);
    assign take     = cls_pop;
    assign res_push = take && cls.field_end;

    // Digit and exponent accumulate: times ten as two shifts and an add.
    assign sum_x10  = {sum_reg[60:0], 3'b000} + {sum_reg[62:0], 1'b0} + 64'(cls.digit);
    assign exp_x10  = {1'b0, exp_reg, 3'b000} + {3'b000, exp_reg, 1'b0} + 20'(cls.digit);
    assign can_keep = (kept_reg < MaxKept);

    // Phase decode for the byte at the head of the queue.
    always_comb
    begin
        phase_upd   = phase_reg;
        exp_upd     = exp_reg;
        exp_neg_upd = exp_neg_reg;
        sign_ok_upd = sign_ok_reg;
        minus_upd   = minus_reg;
        skipped_upd = skipped_reg;
        stopped_upd = stopped_reg;
        take_int    = 1'b0;
        take_frac   = 1'b0;
        unique case (phase_reg)
            PH_SKIP:
            begin
                if (cls.is_minus)
                begin
                    minus_upd = 1'b1;
                    phase_upd = PH_LHS;
                end
                else if (cls.is_dec)
                begin
                    phase_upd = PH_RHS;
                end
                else if (cls.is_digit)
                begin
                    take_int  = 1'b1;
                    phase_upd = PH_LHS;
                end
                else
                begin
                    skipped_upd = 1'b1;
                end
            end
            PH_LHS:
            begin
                if (cls.is_grp)
                begin
                    phase_upd = PH_LHS;
                end
                else if (cls.is_dec)
                begin
                    phase_upd = PH_RHS;
                end
                else if (seen_reg && cls.is_e)
                begin
                    phase_upd = PH_EXP;
                end
                else if (cls.is_digit)
                begin
                    take_int = 1'b1;
                end
                else
                begin
                    phase_upd   = PH_STOP;
                    stopped_upd = 1'b1;
                end
            end
            PH_RHS:
            begin
                if (cls.is_grp)
                begin
                    phase_upd = PH_RHS;
                end
                else if (seen_reg && cls.is_e)
                begin
                    phase_upd = PH_EXP;
                end
                else if (cls.is_digit)
                begin
                    take_frac = 1'b1;
                end
                else
                begin
                    phase_upd   = PH_STOP;
                    stopped_upd = 1'b1;
                end
            end
            PH_EXP:
            begin
                if (cls.is_minus && sign_ok_reg)
                begin
                    exp_neg_upd = 1'b1;
                    sign_ok_upd = 1'b0;
                end
                else if (cls.is_plus && sign_ok_reg)
                begin
                    sign_ok_upd = 1'b0;
                end
                else if (cls.is_digit)
                begin
                    exp_upd     = (exp_x10 > 20'(SAT16)) ? SAT16 : exp_x10[15:0];
                    sign_ok_upd = 1'b0;
                end
                else
                begin
                    phase_upd   = PH_STOP;
                    stopped_upd = 1'b1;
                end
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
    end

    // Significand digit handling shared by integer and fraction digits.
    always_comb
    begin
        seen_upd    = seen_reg;
        sum_upd     = sum_reg;
        kept_upd    = kept_reg;
        frac_upd    = frac_reg;
        dropped_upd = dropped_reg;
        if (take_int || take_frac)
        begin
            seen_upd = 1'b1;
            if (can_keep)
            begin
                sum_upd = sum_x10;
                if (sum_x10 != 64'd0)
                begin
                    kept_upd = kept_reg + 5'd1;
                end
                if (take_frac && (frac_reg != SAT16))
                begin
                    frac_upd = frac_reg + 16'd1;
                end
            end
            else if (take_int && (dropped_reg != SAT16))
            begin
                dropped_upd = dropped_reg + 16'd1;
            end
        end
    end

    // Result of a finished field: scale sum and saturation.
    always_comb
    begin
        ok         = seen_upd && (!cfg.strict_mode || (!skipped_upd && !stopped_upd));
        exp_signed = exp_neg_upd ? -$signed({3'b000, exp_upd}) : $signed({3'b000, exp_upd});
        scale_wide = exp_signed + $signed({3'b000, dropped_upd}) - $signed({3'b000, frac_upd});
        if (scale_wide > 19'sd32767)
        begin
            scale_sat = 16'sh7FFF;
        end
        else if (scale_wide < -19'sd32768)
        begin
            scale_sat = 16'sh8000;
        end
        else
        begin
            scale_sat = scale_wide[15:0];
        end
        res.ok            = ok;
        res.negative      = ok && minus_upd;
        res.significand   = ok ? sum_upd : 64'd0;
        res.decimal_scale = ok ? scale_sat : 16'sd0;
    end

    // Next state: hold when idle, clear after a field's last byte.
    always_comb
    begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        kept_next    = kept_reg;
        dropped_next = dropped_reg;
        frac_next    = frac_reg;
        exp_next     = exp_reg;
        exp_neg_next = exp_neg_reg;
        sign_ok_next = sign_ok_reg;
        seen_next    = seen_reg;
        minus_next   = minus_reg;
        skipped_next = skipped_reg;
        stopped_next = stopped_reg;
        if (take && cls.field_end)
        begin
            phase_next   = PH_SKIP;
            sum_next     = 64'd0;
            kept_next    = 5'd0;
            dropped_next = 16'd0;
            frac_next    = 16'd0;
            exp_next     = 16'd0;
            exp_neg_next = 1'b0;
            sign_ok_next = 1'b1;
            seen_next    = 1'b0;
            minus_next   = 1'b0;
            skipped_next = 1'b0;
            stopped_next = 1'b0;
        end
        else if (take)
        begin
            phase_next   = phase_upd;
            sum_next     = sum_upd;
            kept_next    = kept_upd;
            dropped_next = dropped_upd;
            frac_next    = frac_upd;
            exp_next     = exp_upd;
            exp_neg_next = exp_neg_upd;
            sign_ok_next = sign_ok_upd;
            seen_next    = seen_upd;
            minus_next   = minus_upd;
            skipped_next = skipped_upd;
            stopped_next = stopped_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SKIP;
            sum_reg     <= 64'd0;
            kept_reg    <= 5'd0;
            dropped_reg <= 16'd0;
            frac_reg    <= 16'd0;
            exp_reg     <= 16'd0;
            exp_neg_reg <= 1'b0;
            sign_ok_reg <= 1'b1;
            seen_reg    <= 1'b0;
            minus_reg   <= 1'b0;
            skipped_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            kept_reg    <= kept_next;
            dropped_reg <= dropped_next;
            frac_reg    <= frac_next;
            exp_reg     <= exp_next;
            exp_neg_reg <= exp_neg_next;
            sign_ok_reg <= sign_ok_next;
            seen_reg    <= seen_next;
            minus_reg   <= minus_next;
            skipped_reg <= skipped_next;
            stopped_reg <= stopped_next;
        end
    end

`ifndef SYNTHESIS
    // After a field's last byte the parser starts over in the skip phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && cls.field_end) |=> (phase_reg == PH_SKIP && sum_reg == 64'd0))
        else $error("parser state not cleared after field end");

    // The kept digit count never passes the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n) kept_reg <= MaxKept)
        else $error("kept digit count over limit");

    // A missing value carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.ok) |-> (!res.negative && res.significand == 64'd0 &&
                                   res.decimal_scale == 16'sd0))
        else $error("missing value with nonzero fields");
`endif

endmodule

// ----- sv/decimal_number_text_parser.sv -----
// Order: a byte is written into the input queue and parsed when the parser takes it from
// the queue head; the result of a field's last byte is written into the result queue.
// Throughput: one byte per cycle while the result queue has room for a field's result;
// two-entry queues on both sides of the parser absorb stalls.
// Reset: asynchronous, active low; clears the queues and parser and loads the marks
// and strict mode with their defaults. No clearing pass is needed.
module decimal_number_text_parser
    import dntp_pkg::*;
#(
    parameter int unsigned MAX_SIG_DIGITS = 19
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Byte stream side.
    input  logic              push,
    input  dntp_in_t          item,
    output logic              full,
    // Result side.
    input  logic              pop,
    output dntp_out_t         result,
    output logic              empty,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] decimal_mark_reg;
    logic [7:0] grouping_mark_reg;
    logic       strict_mode_reg;
    logic [1:0] reg_index;
    logic       cfg_write;
    dntp_cfg_t  cfg;
    dntp_cls_t  cls_in;
    dntp_cls_t  cls_out;
    logic       cls_empty;
    logic       cls_pop;
    logic       res_full;
    logic       res_push;
    dntp_out_t  res;

    // Register file.
    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimal_mark_reg  <= DECIMAL_MARK_RST;
            grouping_mark_reg <= GROUPING_MARK_RST;
            strict_mode_reg   <= STRICT_MODE_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_DECIMAL_MARK:  decimal_mark_reg  <= pwdata[7:0];
                REG_GROUPING_MARK: grouping_mark_reg <= pwdata[7:0];
                REG_STRICT_MODE:   strict_mode_reg   <= pwdata[0];
                default:           strict_mode_reg   <= strict_mode_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_index)
            REG_DECIMAL_MARK:  prdata = {24'd0, decimal_mark_reg};
            REG_GROUPING_MARK: prdata = {24'd0, grouping_mark_reg};
            REG_STRICT_MODE:   prdata = {31'd0, strict_mode_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.decimal_mark  = decimal_mark_reg;
    assign cfg.grouping_mark = grouping_mark_reg;
    assign cfg.strict_mode   = strict_mode_reg;

    // Byte classification.
    dntp_front u_front
    (
        .cfg  (cfg),
        .item (item),
        .cls  (cls_in)
    );

    // Queue of classified bytes.
    dntp_fifo #(.WIDTH($bits(dntp_cls_t))) u_cls_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_in),
        .full  (full),
        .pop   (cls_pop),
        .rdata (cls_out),
        .empty (cls_empty)
    );

    // Parser.
    dntp_back #(.MAX_SIG_DIGITS(MAX_SIG_DIGITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cls       (cls_out),
        .cls_empty (cls_empty),
        .cls_pop   (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Result queue.
    dntp_fifo #(.WIDTH($bits(dntp_out_t))) u_res_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// ----- verif/decimal_number_text_parser_tb.sv -----
// Self-checking testbench of the decimal number text parser: byte stream in, parsed numbers out.
module decimal_number_text_parser_tb;
    import dntp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SIG_DIGITS = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_LEN = 300;
    localparam int PHASE_BYTES = 200;
    localparam int LONG_RUN = 30;

    typedef logic [7:0] text_t[$];

    // Predicts the parsed number of each field and checks the result transfers against it.
    class number_checker;
        logic [7:0] dec_mark;
        logic [7:0] grp_mark;
        logic strict;

        dntp_phase_t ph;
        logic [63:0] sig_acc;
        int unsigned kept;
        int unsigned dropped;
        int unsigned frac_cnt;
        int unsigned exp_val;
        bit exp_neg;
        bit exp_sign_ok;
        bit digit_seen;
        bit minus;
        bit skipped;
        bit stopped;

        dntp_out_t pending_numbers[$];
        int errors;
        int numbers_checked;

        function new();
            dec_mark = DECIMAL_MARK_RST;
            grp_mark = GROUPING_MARK_RST;
            strict = STRICT_MODE_RST;
            errors = 0;
            numbers_checked = 0;
            clear_field();
        endfunction

        function void clear_field();
            ph = PH_SKIP;
            sig_acc = '0;
            kept = 0;
            dropped = 0;
            frac_cnt = 0;
            exp_val = 0;
            exp_neg = 0;
            exp_sign_ok = 1;
            digit_seen = 0;
            minus = 0;
            skipped = 0;
            stopped = 0;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= CHAR_ZERO && b <= CHAR_NINE;
        endfunction

        function bit is_e(logic [7:0] b);
            return b == CHAR_LOWER_E || b == CHAR_UPPER_E;
        endfunction

        // Digits past the kept limit only move the scale on the integer side.
        function void take_digit(int unsigned d, bit frac);
            digit_seen = 1;
            if (kept < MAX_SIG_DIGITS) begin
                sig_acc = sig_acc * 10 + 64'(d);
                if (sig_acc != 0)
                    kept++;
                if (frac && frac_cnt < SAT16)
                    frac_cnt++;
            end
            else if (!frac && dropped < SAT16) begin
                dropped++;
            end
        endfunction

        function void stop_parse();
            ph = PH_STOP;
            stopped = 1;
        endfunction

        // Parser state update for one byte; test order decides mark clashes.
        function void parse_byte(logic [7:0] b);
            case (ph)
                PH_SKIP:
                    if (b == CHAR_MINUS) begin
                        minus = 1;
                        ph = PH_LHS;
                    end
                    else if (b == dec_mark) begin
                        ph = PH_RHS;
                    end
                    else if (is_digit(b)) begin
                        take_digit(b - CHAR_ZERO, 0);
                        ph = PH_LHS;
                    end
                    else begin
                        skipped = 1;
                    end
                PH_LHS:
                    if (b != grp_mark) begin
                        if (b == dec_mark)
                            ph = PH_RHS;
                        else if (digit_seen && is_e(b))
                            ph = PH_EXP;
                        else if (is_digit(b))
                            take_digit(b - CHAR_ZERO, 0);
                        else
                            stop_parse();
                    end
                PH_RHS:
                    if (b != grp_mark) begin
                        if (digit_seen && is_e(b))
                            ph = PH_EXP;
                        else if (is_digit(b))
                            take_digit(b - CHAR_ZERO, 1);
                        else
                            stop_parse();
                    end
                PH_EXP:
                    if (b == CHAR_MINUS && exp_sign_ok) begin
                        exp_neg = 1;
                        exp_sign_ok = 0;
                    end
                    else if (b == CHAR_PLUS && exp_sign_ok) begin
                        exp_sign_ok = 0;
                    end
                    else if (is_digit(b)) begin
                        exp_val = exp_val * 10 + (b - CHAR_ZERO);
                        if (exp_val > SAT16)
                            exp_val = SAT16;
                        exp_sign_ok = 0;
                    end
                    else begin
                        stop_parse();
                    end
                default: ;
            endcase
        endfunction

        // Called for every accepted input transfer; the last byte of a field queues a number.
        function void take_text_byte(dntp_in_t x);
            dntp_out_t num;
            int s;
            parse_byte(x.text_byte);
            if (!x.field_end)
                return;
            num = '0;
            if (digit_seen && (!strict || (!skipped && !stopped))) begin
                s = (exp_neg ? -int'(exp_val) : int'(exp_val)) + int'(dropped) - int'(frac_cnt);
                if (s > 32767)
                    s = 32767;
                if (s < -32768)
                    s = -32768;
                num.ok = 1'b1;
                num.negative = minus;
                num.significand = sig_acc;
                num.decimal_scale = 16'(s);
            end
            pending_numbers.push_back(num);
            clear_field();
        endfunction

        // Called for every accepted result transfer.
        function void check_number(dntp_out_t got);
            dntp_out_t want;
            numbers_checked++;
            if (pending_numbers.size() == 0) begin
                $error("result transfer with no number pending: ok %0b significand %0d",
                       got.ok, got.significand);
                errors++;
                return;
            end
            want = pending_numbers.pop_front();
            if (got.ok !== want.ok) begin
                $error("ok: expected %0b actual %0b", want.ok, got.ok);
                errors++;
            end
            if (got.negative !== want.negative) begin
                $error("negative: expected %0b actual %0b", want.negative, got.negative);
                errors++;
            end
            if (got.significand !== want.significand) begin
                $error("significand: expected %0d actual %0d", want.significand, got.significand);
                errors++;
            end
            if (got.decimal_scale !== want.decimal_scale) begin
                $error("decimal_scale: expected %0d actual %0d",
                       want.decimal_scale, got.decimal_scale);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    dntp_in_t item;
    logic full;
    logic pop;
    dntp_out_t result;
    logic empty;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    number_checker sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_trigger;
    int hold_taken;
    int hold_left;
    int quiet_cycles;
    int bytes_sent;
    int fields_sent;
    int full_cycles;
    int settings_used;

    decimal_number_text_parser #(
        .MAX_SIG_DIGITS(MAX_SIG_DIGITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .item(item),
        .full(full),
        .pop(pop),
        .result(result),
        .empty(empty),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Clock with a 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever the sequence asks for one.
    always @(posedge clk)
    begin
        if (hold_trigger != hold_taken) begin
            hold_taken = hold_trigger;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
        end
        else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: feeds accepted transfers to the checker and guards against a hang.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.take_text_byte(item);
            if (pop && !empty)
                sb.check_number(result);
            if (push && full)
                full_cycles++;
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d numbers still pending",
                         quiet_cycles, sb.pending_numbers.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            1: begin send_idle_pct = 48; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 48; end
            3: begin send_idle_pct = 22; recv_stall_pct = 22; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DECIMAL_MARK: sb.dec_mark = val[7:0];
            REG_GROUPING_MARK: sb.grp_mark = val[7:0];
            REG_STRICT_MODE: sb.strict = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [7:0] dec, input logic [7:0] grp, input logic st);
        write_reg(REG_DECIMAL_MARK, {24'b0, dec});
        write_reg(REG_GROUPING_MARK, {24'b0, grp});
        write_reg(REG_STRICT_MODE, {31'b0, st});
        settings_used++;
    endtask

    // Offers one byte with optional idle gaps and waits for its transfer.
    task automatic send_byte(input dntp_in_t x);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= x;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_field(input text_t t);
        dntp_in_t x;
        for (int i = 0; i < t.size(); i++) begin
            x.text_byte = t[i];
            x.field_end = (i == t.size() - 1);
            send_byte(x);
        end
        fields_sent++;
    endtask

    // Stops offering and waits until every pending number has come out.
    // The first edge lets the monitor note the last byte before the count is read.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending_numbers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic text_t text_of(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    // Leading zeros show up often so that they get skipped in the kept count.
    function automatic logic [7:0] rand_digit();
        if ($urandom_range(3) == 0)
            return CHAR_ZERO;
        return CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic void add_digits(ref text_t t, input int n);
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(7) == 0)
                t.push_back(sb.grp_mark);
            t.push_back(rand_digit());
        end
    endfunction

    // A number with random content under the current marks, at times with a random byte around it.
    function automatic text_t make_number();
        text_t t;
        int pick;
        if ($urandom_range(9) == 0)
            t.push_back(8'($urandom_range(255)));
        if ($urandom_range(2) == 0)
            t.push_back(CHAR_MINUS);
        add_digits(t, ($urandom_range(5) == 0) ? $urandom_range(26, 18) : $urandom_range(4));
        if ($urandom_range(1) == 1) begin
            t.push_back(sb.dec_mark);
            add_digits(t, ($urandom_range(7) == 0) ? $urandom_range(24, 15) : $urandom_range(5));
        end
        if ($urandom_range(2) == 0) begin
            t.push_back(($urandom_range(1) == 1) ? CHAR_LOWER_E : CHAR_UPPER_E);
            pick = $urandom_range(2);
            if (pick == 1)
                t.push_back(CHAR_MINUS);
            else if (pick == 2)
                t.push_back(CHAR_PLUS);
            for (int i = $urandom_range(5); i > 0; i--)
                t.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(9) == 0)
            t.push_back(8'($urandom_range(255)));
        if (t.size() == 0)
            t.push_back(rand_digit());
        return t;
    endfunction

    // Mostly numbers, some with one byte corrupted, some plain noise.
    function automatic text_t make_field();
        text_t t;
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            t = make_number();
        end
        else if (pick < 88) begin
            t = make_number();
            t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
        end
        else begin
            for (int i = $urandom_range(5, 1); i > 0; i--)
                t.push_back(8'($urandom_range(255)));
        end
        return t;
    endfunction

    initial
    begin
        text_t t;
        int phase_start;

        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        pop = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_trigger = 0;
        hold_taken = 0;
        hold_left = 0;
        quiet_cycles = 0;
        bytes_sent = 0;
        fields_sent = 0;
        full_cycles = 0;
        settings_used = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed fields under the reset marks and strict mode.
        send_field(text_of("9"));
        send_field(text_of("-1,2.5e-3"));
        send_field(text_of(".5E+7"));
        send_field(text_of("x7"));
        send_field(text_of("1e"));
        send_field(text_of("3-"));
        t = {8'hFF};
        send_field(t);
        t = {8'h00};
        send_field(t);
        settle();

        // Long receiver hold-off while single-digit fields keep coming, so the input backs up.
        hold_trigger++;
        for (int i = 0; i < 40; i++)
            send_field(text_of("5"));
        settle();

        // Random phases over several register settings and idle patterns.
        for (int k = 0; k < 8; k++) begin
            set_idle(k % 4);
            case (k)
                0: apply_setting(8'h2E, 8'h2C, 1'b1);
                1: apply_setting(8'h2C, 8'h2E, 1'b0);
                2: apply_setting(8'h00, 8'hFF, 1'b1);
                3: apply_setting(8'hFF, 8'h00, 1'b0);
                4: apply_setting(CHAR_MINUS, 8'h2E, 1'b1);
                5: apply_setting(CHAR_UPPER_E, CHAR_LOWER_E, 1'b0);
                6: apply_setting(CHAR_ZERO + 8'd5, CHAR_ZERO + 8'd5, 1'b1);
                default: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                                       1'($urandom_range(1)));
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_field(make_field());
            settle();
        end

        // Digit overflow: one field with a long integer part, one with a long fraction.
        set_idle(0);
        apply_setting(8'h2E, 8'h2C, 1'b1);
        t = {CHAR_ZERO + 8'd1};
        for (int i = 0; i < LONG_RUN; i++)
            t.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        t = {t, text_of("e-4")};
        send_field(t);
        t = {CHAR_ZERO, 8'h2E};
        for (int i = 0; i < LONG_RUN; i++)
            t.push_back(CHAR_ZERO);
        t = {t, text_of("7e5")};
        send_field(t);
        settle();

        $display("Covered %0d bytes in %0d fields under %0d register settings;",
                 bytes_sent, fields_sent, settings_used);
        $display("%0d numbers checked, input held back in %0d cycles.",
                 sb.numbers_checked, full_cycles);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
